// ===== src/ghal_pkg.sv =====
// shared types and constants for the generational handle allocator
// no dependencies; used by ghal_slot_ram, ghal_free_stack and the top level
`default_nettype none

package ghal_pkg;

  localparam int unsigned GEN_W      = 16;
  localparam int unsigned HANDLE_W   = 32;
  localparam int unsigned MAX_LIST   = 16;
  localparam int unsigned LIST_CNT_W = 5;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_CHECK   = 2'd2,
    CMD_LIST    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_RANGE   = 3'd1,
    ST_FREE    = 3'd2,
    ST_STALE   = 3'd3,
    ST_BACKEND = 3'd4,
    ST_FULL    = 3'd5,
    ST_EMPTY   = 3'd6
  } status_e;

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_DISPATCH  = 9'b000000010,
    S_POPPED    = 9'b000000100,
    S_ALLOC_FIN = 9'b000001000,
    S_RC        = 9'b000010000,
    S_LREAD     = 9'b000100000,
    S_LEVAL     = 9'b001000000,
    S_LOUT      = 9'b010000000,
    S_OUT       = 9'b100000000
  } state_e;

  // one slot table entry
  typedef struct packed {
    logic             occ;
    logic [GEN_W-1:0] gen;
  } slot_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stack_ctrl_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } ram_ctrl_t;

endpackage

`default_nettype wire

// ===== src/generational_handle_allocator_core.sv =====
// Generational handle allocator. Handles are a 16-bit generation above an
// index field of INDEX_FIELD_BITS bits. Items are taken one at a time: the
// block stalls its input from acceptance until the last result of the item
// has been taken. Allocate, release and check pass through dispatch, a pop
// state when allocate takes a slot from the free stack, whose read is
// registered, a slot table state (read data for release and check, the write
// for allocate), then the result state and idle. A full table or an index
// out of range goes straight from dispatch to the result. List reads and
// evaluates each grown slot in turn, presents every handle before the last
// in a list output state as the next is found, and stops after 16 handles.
// A stalled output holds the sequencer in its output state. Slots above the
// grown count are never read, so the slot table needs no clearing after reset.
// depends on ghal_pkg, ghal_slot_ram and ghal_free_stack
`default_nettype none

module generational_handle_allocator_core #(
  parameter int unsigned SLOT_COUNT       = 16,
  parameter int unsigned INDEX_FIELD_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [31:0] handle_i,
  input  wire logic        backend_ok_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      result_handle_o,
  output logic [2:0]       status_o,
  output logic             any_live_o,
  output logic             last_o
);

  localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CNT_W = $clog2(SLOT_COUNT + 1);
  localparam int unsigned GW    = ghal_pkg::GEN_W;
  localparam int unsigned HW    = ghal_pkg::HANDLE_W;
  localparam int unsigned LW    = ghal_pkg::LIST_CNT_W;
  localparam logic [HW-1:0] IDX_MASK = HW'((64'd1 << INDEX_FIELD_BITS) - 64'd1);

  function automatic logic [HW-1:0] make_handle(input logic [IDX_W-1:0] slot,
                                                input logic [GW-1:0] gen);
    make_handle = (HW'(gen) << INDEX_FIELD_BITS) | HW'(slot);
  endfunction

  ghal_pkg::state_e  state_q, state_d;
  ghal_pkg::cmd_e    cmd_q;
  logic [HW-1:0]     handle_q;
  logic              ok_q;
  logic [CNT_W-1:0]  grown_q, grown_d;
  logic [CNT_W-1:0]  live_q, live_d;
  logic [IDX_W-1:0]  slot_q, slot_d;
  logic              gen_zero_q, gen_zero_d;
  logic [CNT_W-1:0]  i_q, i_d;
  logic [LW-1:0]     n_q, n_d;
  logic              pend_v_q, pend_v_d;
  logic [HW-1:0]     pend_h_q, pend_h_d;

  logic              out_valid_q, out_valid_d;
  logic [HW-1:0]     res_h_q, res_h_d;
  ghal_pkg::status_e status_q, status_d;
  logic              any_live_q, any_live_d;
  logic              last_q, last_d;

  ghal_pkg::stack_ctrl_t stk_ctrl;
  logic [IDX_W-1:0]      push_idx;
  logic [IDX_W-1:0]      stk_top;
  logic [CNT_W-1:0]      stk_count;

  ghal_pkg::ram_ctrl_t   ram_ctrl;
  logic [IDX_W-1:0]      ram_waddr, ram_raddr;
  ghal_pkg::slot_t       ram_wdata, ram_rdata;

  logic [HW-1:0]    idx32, hgen32;
  logic [IDX_W-1:0] req_idx;
  logic             idx_in_range, gen_match;
  logic             in_accept;

  assign in_accept    = in_valid_i && !in_stall_o;
  assign in_stall_o   = (state_q != ghal_pkg::S_IDLE);
  assign idx32        = handle_q & IDX_MASK;
  assign hgen32       = handle_q >> INDEX_FIELD_BITS;
  assign req_idx      = idx32[IDX_W-1:0];
  assign idx_in_range = idx32 < HW'(grown_q);
  // a wide handle generation never matches the stored one
  assign gen_match    = (HW'(ram_rdata.gen) == hgen32);

  ghal_slot_ram #(
    .DEPTH (SLOT_COUNT)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .ctrl_i  (ram_ctrl),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ghal_free_stack #(
    .DEPTH (SLOT_COUNT)
  ) u_free_stack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (stk_ctrl),
    .push_idx_i (push_idx),
    .top_o      (stk_top),
    .count_o    (stk_count)
  );

  always_comb begin
    logic              emit;
    logic [HW-1:0]     emit_h;
    ghal_pkg::status_e emit_st;
    logic              emit_last;
    logic [GW-1:0]     gen_sel;

    emit      = 1'b0;
    emit_h    = '0;
    emit_st   = ghal_pkg::ST_OK;
    emit_last = 1'b1;
    gen_sel   = gen_zero_q ? '0 : ram_rdata.gen;

    state_d    = state_q;
    grown_d    = grown_q;
    live_d     = live_q;
    slot_d     = slot_q;
    gen_zero_d = gen_zero_q;
    i_d        = i_q;
    n_d        = n_q;
    pend_v_d   = pend_v_q;
    pend_h_d   = pend_h_q;

    out_valid_d = out_valid_q;
    res_h_d     = res_h_q;
    status_d    = status_q;
    any_live_d  = any_live_q;
    last_d      = last_q;

    stk_ctrl  = '0;
    push_idx  = slot_q;
    ram_ctrl  = '0;
    ram_waddr = slot_q;
    ram_wdata = '0;
    ram_raddr = slot_q;

    case (state_q)
      ghal_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = ghal_pkg::S_DISPATCH;
        end
      end
      ghal_pkg::S_DISPATCH: begin
        case (cmd_q)
          ghal_pkg::CMD_ALLOC: begin
            if (stk_count != '0) begin
              stk_ctrl.pop = 1'b1;
              state_d      = ghal_pkg::S_POPPED;
            end else if (grown_q < CNT_W'(SLOT_COUNT)) begin
              // fresh slot: generation starts at zero, table entry not read
              slot_d     = grown_q[IDX_W-1:0];
              gen_zero_d = 1'b1;
              grown_d    = grown_q + CNT_W'(1);
              state_d    = ghal_pkg::S_ALLOC_FIN;
            end else begin
              emit    = 1'b1;
              emit_st = ghal_pkg::ST_FULL;
              state_d = ghal_pkg::S_OUT;
            end
          end
          ghal_pkg::CMD_RELEASE, ghal_pkg::CMD_CHECK: begin
            if (!idx_in_range) begin
              emit    = 1'b1;
              emit_st = ghal_pkg::ST_RANGE;
              state_d = ghal_pkg::S_OUT;
            end else begin
              ram_ctrl.rd_en = 1'b1;
              ram_raddr      = req_idx;
              state_d        = ghal_pkg::S_RC;
            end
          end
          ghal_pkg::CMD_LIST: begin
            i_d      = '0;
            n_d      = '0;
            pend_v_d = 1'b0;
            state_d  = ghal_pkg::S_LREAD;
          end
          default: begin
            state_d = ghal_pkg::S_IDLE;
          end
        endcase
      end
      ghal_pkg::S_POPPED: begin
        slot_d         = stk_top;
        gen_zero_d     = 1'b0;
        ram_ctrl.rd_en = 1'b1;
        ram_raddr      = stk_top;
        state_d        = ghal_pkg::S_ALLOC_FIN;
      end
      ghal_pkg::S_ALLOC_FIN: begin
        ram_ctrl.wr_en = 1'b1;
        ram_waddr      = slot_q;
        ram_wdata.occ  = ok_q;
        ram_wdata.gen  = gen_sel;
        emit           = 1'b1;
        state_d        = ghal_pkg::S_OUT;
        if (ok_q) begin
          live_d = live_q + CNT_W'(1);
          emit_h = make_handle(slot_q, gen_sel);
        end else begin
          stk_ctrl.push = 1'b1;
          push_idx      = slot_q;
          emit_st       = ghal_pkg::ST_BACKEND;
        end
      end
      ghal_pkg::S_RC: begin
        emit    = 1'b1;
        state_d = ghal_pkg::S_OUT;
        if (cmd_q == ghal_pkg::CMD_RELEASE) begin
          if (!ram_rdata.occ) begin
            emit_st = ghal_pkg::ST_FREE;
          end else if (!gen_match) begin
            emit_st = ghal_pkg::ST_STALE;
          end else begin
            ram_ctrl.wr_en = 1'b1;
            ram_waddr      = req_idx;
            ram_wdata.occ  = 1'b0;
            ram_wdata.gen  = ram_rdata.gen + GW'(1);
            stk_ctrl.push  = 1'b1;
            push_idx       = req_idx;
            if (live_q != '0) begin
              live_d = live_q - CNT_W'(1);
            end
          end
        end else begin
          if (!gen_match) begin
            emit_st = ghal_pkg::ST_STALE;
          end else if (!ram_rdata.occ) begin
            emit_st = ghal_pkg::ST_FREE;
          end
        end
      end
      ghal_pkg::S_LREAD: begin
        if ((i_q < grown_q) && (n_q != LW'(ghal_pkg::MAX_LIST))) begin
          ram_ctrl.rd_en = 1'b1;
          ram_raddr      = i_q[IDX_W-1:0];
          state_d        = ghal_pkg::S_LEVAL;
        end else begin
          emit    = 1'b1;
          state_d = ghal_pkg::S_OUT;
          if (pend_v_q) begin
            emit_h = pend_h_q;
          end else begin
            emit_st = ghal_pkg::ST_EMPTY;
          end
        end
      end
      ghal_pkg::S_LEVAL: begin
        i_d     = i_q + CNT_W'(1);
        state_d = ghal_pkg::S_LREAD;
        if (ram_rdata.occ) begin
          // hold the newest live handle back until we know whether it is the last
          pend_h_d = make_handle(i_q[IDX_W-1:0], ram_rdata.gen);
          pend_v_d = 1'b1;
          n_d      = n_q + LW'(1);
          if (pend_v_q) begin
            emit      = 1'b1;
            emit_h    = pend_h_q;
            emit_last = 1'b0;
            state_d   = ghal_pkg::S_LOUT;
          end
        end
      end
      ghal_pkg::S_LOUT: begin
        if (!out_stall_i) begin
          out_valid_d = 1'b0;
          state_d     = ghal_pkg::S_LREAD;
        end
      end
      ghal_pkg::S_OUT: begin
        if (!out_stall_i) begin
          out_valid_d = 1'b0;
          state_d     = ghal_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ghal_pkg::S_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_d = 1'b1;
      res_h_d     = emit_h;
      status_d    = emit_st;
      last_d      = emit_last;
      any_live_d  = (live_d != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ghal_pkg::S_IDLE;
      grown_q     <= '0;
      live_q      <= '0;
      out_valid_q <= 1'b0;
      n_q         <= '0;
      pend_v_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      grown_q     <= grown_d;
      live_q      <= live_d;
      out_valid_q <= out_valid_d;
      n_q         <= n_d;
      pend_v_q    <= pend_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q    <= ghal_pkg::cmd_e'(command_i);
      handle_q <= handle_i;
      ok_q     <= backend_ok_i;
    end
    slot_q     <= slot_d;
    gen_zero_q <= gen_zero_d;
    i_q        <= i_d;
    pend_h_q   <= pend_h_d;
    res_h_q    <= res_h_d;
    status_q   <= status_d;
    any_live_q <= any_live_d;
    last_q     <= last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign result_handle_o = res_h_q;
  assign status_o        = status_q;
  assign any_live_o      = any_live_q;
  assign last_o          = last_q;

  // a result is only presented while the sequencer waits on the output
  a_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (state_q == ghal_pkg::S_OUT || state_q == ghal_pkg::S_LOUT))
    else $error("result valid outside an output state");

  // every grown slot is either live or on the free stack
  a_slot_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ghal_pkg::S_IDLE) |->
      (({1'b0, live_q} + {1'b0, stk_count}) == {1'b0, grown_q}))
    else $error("live plus free slots differ from grown slots");

  a_list_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= LW'(ghal_pkg::MAX_LIST))
    else $error("list emitted more than the handle limit");

  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == ghal_pkg::S_DISPATCH && !out_valid_q))
    else $error("accepted item did not start dispatch");

endmodule

`default_nettype wire

// ===== src/ghal_slot_ram.sv =====
// slot table memory: occupied flag and generation per slot
// one write port, one registered read port; uses ghal_pkg
`default_nettype none

module ghal_slot_ram #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk_i,
  input  wire ghal_pkg::ram_ctrl_t  ctrl_i,
  input  wire logic [IdxW-1:0]      waddr_i,
  input  wire ghal_pkg::slot_t      wdata_i,
  input  wire logic [IdxW-1:0]      raddr_i,
  output ghal_pkg::slot_t           rdata_o
);

  ghal_pkg::slot_t mem [DEPTH];
  ghal_pkg::slot_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[waddr_i] <= wdata_i;
    end
    if (ctrl_i.rd_en) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/ghal_free_stack.sv =====
// lifo of free slot indices with its fill count
// popped index appears registered in the cycle after pop; uses ghal_pkg
`default_nettype none

module ghal_free_stack #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire ghal_pkg::stack_ctrl_t  ctrl_i,
  input  wire logic [IdxW-1:0]        push_idx_i,
  output logic [IdxW-1:0]             top_o,
  output logic [CntW-1:0]             count_o
);

  logic [IdxW-1:0] mem [DEPTH];
  logic [IdxW-1:0] top_q;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] count_m1;
  logic            push_ok;

  assign count_m1 = count_q - CntW'(1);
  // a push onto a full stack is dropped
  assign push_ok  = ctrl_i.push && (count_q < CntW'(DEPTH));

  always_comb begin
    count_d = count_q;
    if (push_ok) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl_i.pop) begin
      count_d = count_m1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem[count_q[IdxW-1:0]] <= push_idx_i;
    end
    if (ctrl_i.pop) begin
      top_q <= mem[count_m1[IdxW-1:0]];
    end
  end

  assign top_o   = top_q;
  assign count_o = count_q;

endmodule

`default_nettype wire

// ===== bench/ghal_result_checker.sv =====
// result checker for the generational handle allocator: watches both channels,
// predicts every result from its own copy of the slot table and compares them
// depends on ghal_pkg
module ghal_result_checker
  import ghal_pkg::*;
#(
  parameter int unsigned SLOTS    = 16,
  parameter int unsigned IDX_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  command_i,
  input  logic [31:0] handle_i,
  input  logic        backend_ok_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] result_handle_i,
  input  logic [2:0]  status_i,
  input  logic        any_live_i,
  input  logic        last_i,
  output int          fails_o,
  output int          pending_o,
  output int          items_o,
  output int          results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] handle;
    status_e     status;
    logic        any_live;
    logic        last;
  } slot_result_t;

  slot_result_t expected_results_q[$];

  // shadow of the slot table
  logic [15:0] gen_tbl [SLOTS];
  logic        occ_tbl [SLOTS];
  int unsigned free_idx [SLOTS];
  int unsigned free_cnt;
  int unsigned grown_cnt;
  int unsigned live_cnt;

  int fail_cnt;
  int item_cnt;
  int result_cnt;

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      gen_tbl[i]  = '0;
      occ_tbl[i]  = 1'b0;
      free_idx[i] = 0;
    end
    free_cnt   = 0;
    grown_cnt  = 0;
    live_cnt   = 0;
    fail_cnt   = 0;
    item_cnt   = 0;
    result_cnt = 0;
    fails_o    = 0;
    pending_o  = 0;
    items_o    = 0;
    results_o  = 0;
  end

  task automatic report_mismatch(input string what);
    if (fail_cnt < 20) $display("[%0t] mismatch: %s", $realtime, what);
    fail_cnt++;
  endtask

  function automatic logic [31:0] form_handle(input int unsigned slot, input logic [15:0] gen);
    logic [63:0] wide;
    wide = {48'b0, gen} << IDX_BITS;
    wide = wide | 64'(slot);
    return wide[31:0];
  endfunction

  task automatic add_result(input logic [31:0] h, input status_e st, input logic is_last);
    slot_result_t r;
    r.handle   = h;
    r.status   = st;
    r.any_live = (live_cnt != 0);
    r.last     = is_last;
    expected_results_q = {expected_results_q, r};
  endtask

  task automatic push_free(input int unsigned slot);
    if (free_cnt < SLOTS) begin
      free_idx[free_cnt] = slot;
      free_cnt++;
    end
  endtask

  task automatic predict_slot_results(input cmd_e cmd, input logic [31:0] h, input logic ok);
    logic [31:0] idx;
    logic [31:0] hgen;
    int          slot;
    int          n;
    status_e     st;
    idx  = h & ((32'h1 << IDX_BITS) - 32'h1);
    hgen = h >> IDX_BITS;
    case (cmd)
      CMD_ALLOC: begin
        slot = -1;
        if (free_cnt > 0) begin
          free_cnt--;
          slot = free_idx[free_cnt];
        end else if (grown_cnt < SLOTS) begin
          slot = grown_cnt;
          grown_cnt++;
        end
        if (slot < 0) begin
          add_result(32'h0, ST_FULL, 1'b1);
        end else if (ok) begin
          occ_tbl[slot] = 1'b1;
          live_cnt++;
          add_result(form_handle(slot, gen_tbl[slot]), ST_OK, 1'b1);
        end else begin
          // failed backend: slot goes back, generation kept
          push_free(slot);
          add_result(32'h0, ST_BACKEND, 1'b1);
        end
      end
      CMD_RELEASE: begin
        if (idx >= grown_cnt || idx >= SLOTS) begin
          st = ST_RANGE;
        end else if (!occ_tbl[idx]) begin
          st = ST_FREE;
        end else if ({16'b0, gen_tbl[idx]} != hgen) begin
          st = ST_STALE;
        end else begin
          occ_tbl[idx] = 1'b0;
          gen_tbl[idx] = gen_tbl[idx] + 16'd1;
          push_free(idx);
          if (live_cnt > 0) live_cnt--;
          st = ST_OK;
        end
        add_result(32'h0, st, 1'b1);
      end
      CMD_CHECK: begin
        // generation is checked before occupancy here
        if (idx >= grown_cnt || idx >= SLOTS) st = ST_RANGE;
        else if ({16'b0, gen_tbl[idx]} != hgen) st = ST_STALE;
        else if (!occ_tbl[idx]) st = ST_FREE;
        else st = ST_OK;
        add_result(32'h0, st, 1'b1);
      end
      default: begin
        n = 0;
        for (int i = 0; i < grown_cnt && i < SLOTS && n < MAX_LIST; i++) begin
          if (occ_tbl[i]) begin
            add_result(form_handle(i, gen_tbl[i]), ST_OK, 1'b0);
            n++;
          end
        end
        if (n == 0) add_result(32'h0, ST_EMPTY, 1'b1);
        else expected_results_q[$].last = 1'b1;
      end
    endcase
  endtask

  always @(posedge clk_i) begin
    slot_result_t exp_r;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        result_cnt++;
        if (expected_results_q.size() == 0) begin
          report_mismatch($sformatf("result %08h with no item pending", result_handle_i));
        end else begin
          exp_r = expected_results_q.pop_front();
          if (result_handle_i !== exp_r.handle)
            report_mismatch($sformatf("handle %08h, expected %08h",
                                      result_handle_i, exp_r.handle));
          if (status_i !== exp_r.status)
            report_mismatch($sformatf("status %0d, expected %0d", status_i, exp_r.status));
          if (any_live_i !== exp_r.any_live)
            report_mismatch($sformatf("any_live %b, expected %b", any_live_i, exp_r.any_live));
          if (last_i !== exp_r.last)
            report_mismatch($sformatf("last %b, expected %b", last_i, exp_r.last));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        item_cnt++;
        predict_slot_results(cmd_e'(command_i), handle_i, backend_ok_i);
      end
    end
    fails_o   <= fail_cnt;
    pending_o <= expected_results_q.size();
    items_o   <= item_cnt;
    results_o <= result_cnt;
  end

endmodule

// ===== bench/tb_generational_handle_allocator_core.sv =====
// top of the allocator testbench: clock, reset, directed and random items
// under several idling phases, and the verdict
// depends on ghal_pkg, generational_handle_allocator_core and ghal_result_checker
module tb_generational_handle_allocator_core;
  timeunit 1ns;
  timeprecision 1ps;
  import ghal_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int DRAIN       = 40;
  localparam int RAND_PER_PH = 23;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic [1:0]  command    = 2'b0;
  logic [31:0] handle     = 32'h0;
  logic        backend_ok = 1'b0;
  logic        out_stall  = 1'b0;

  logic        in_stall;
  logic        out_valid;
  logic [31:0] result_handle;
  logic [2:0]  status;
  logic        any_live;
  logic        last;

  int fails;
  int pending;
  int items_seen;
  int results_seen;

  int idle_pct  = 0;
  int stall_pct = 0;

  // handles seen on the result channel, reused for release and check
  logic [31:0] handle_pool[$];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  generational_handle_allocator_core dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .command_i      (command),
    .handle_i       (handle),
    .backend_ok_i   (backend_ok),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .result_handle_o(result_handle),
    .status_o       (status),
    .any_live_o     (any_live),
    .last_o         (last)
  );

  ghal_result_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .command_i      (command),
    .handle_i       (handle),
    .backend_ok_i   (backend_ok),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .result_handle_i(result_handle),
    .status_i       (status),
    .any_live_i     (any_live),
    .last_i         (last),
    .fails_o        (fails),
    .pending_o      (pending),
    .items_o        (items_seen),
    .results_o      (results_seen)
  );

  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall && status == ST_OK) begin
      handle_pool = {handle_pool, result_handle};
      if (handle_pool.size() > 24) void'(handle_pool.pop_front());
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("no handshake for %0d cycles, %0d results still pending", QUIET_LIMIT, pending);
    $display("** generational_handle_allocator_core: FAILED **");
    $finish;
  end

  // called at a falling edge; returns at the falling edge after acceptance
  // with valid still high so a back-to-back item needs no second assignment
  task automatic send_item(input cmd_e cmd, input logic [31:0] h, input logic ok);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 40) gap++;
    if (!in_valid && gap == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    handle     <= h;
    backend_ok <= ok;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_handle();
    int          r;
    logic [31:0] h;
    r = $urandom_range(99);
    if (handle_pool.size() > 0 && r < 60) begin
      h = handle_pool[$urandom_range(handle_pool.size() - 1)];
    end else if (handle_pool.size() > 0 && r < 75) begin
      // neighbor generation of a real handle
      h = handle_pool[$urandom_range(handle_pool.size() - 1)];
      if ($urandom_range(1)) h[31:16] = h[31:16] + 16'd1;
      else h[31:16] = h[31:16] - 16'd1;
    end else if (r < 88) begin
      h = {16'($urandom_range(3)), 16'($urandom_range(17))};
    end else begin
      h = $urandom();
    end
    return h;
  endfunction

  task automatic random_item();
    int          r;
    cmd_e        cmd;
    logic [31:0] h;
    logic        ok;
    r  = $urandom_range(99);
    ok = ($urandom_range(99) < 85);
    h  = pick_handle();
    if (r < 35) cmd = CMD_ALLOC;
    else if (r < 65) cmd = CMD_RELEASE;
    else if (r < 85) cmd = CMD_CHECK;
    else cmd = CMD_LIST;
    send_item(cmd, h, ok);
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part, no idling
    send_item(CMD_LIST,    32'h0000_0000, 1'b0);  // empty list
    send_item(CMD_RELEASE, 32'hFFFF_FFFF, 1'b1);  // index out of range
    send_item(CMD_ALLOC,   32'h0000_0000, 1'b0);  // backend fails, slot 0 freed
    send_item(CMD_ALLOC,   32'hFFFF_FFFF, 1'b1);  // pops slot 0
    send_item(CMD_CHECK,   32'h0001_0000, 1'b0);  // stale
    send_item(CMD_RELEASE, 32'hFFFF_0000, 1'b0);  // stale
    send_item(CMD_RELEASE, 32'h0000_0000, 1'b1);  // ok, generation bumps
    send_item(CMD_RELEASE, 32'h0000_0000, 1'b1);  // not occupied beats stale
    send_item(CMD_CHECK,   32'h0001_0000, 1'b1);  // matching gen but free
    for (int i = 0; i < 16; i++) send_item(CMD_ALLOC, 32'h0, 1'b1);
    send_item(CMD_ALLOC,   32'h0000_0000, 1'b0);  // full wins over backend fail
    send_item(CMD_LIST,    32'h0000_0000, 1'b1);  // long list
    send_item(CMD_CHECK,   32'h0000_0010, 1'b1);  // first index past the table

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 49; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 49; end
        default: begin idle_pct = 30; stall_pct = 30; end
      endcase
      repeat (RAND_PER_PH) random_item();
    end

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("ran %0d items and checked %0d results over four idling phases", items_seen,
             results_seen);
    $display("covered range, free, stale, backend, full and list cases");
    if (fails == 0 && pending == 0) begin
      $display("** generational_handle_allocator_core: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results left pending", fails, pending);
      $display("** generational_handle_allocator_core: FAILED **");
    end
    $finish;
  end

endmodule
